[hw/rtl/tscg_pkg.sv]
// ----------------------------------------------------------------------------
// tscg_pkg
// Shared types, constants and helpers for the two-segment color gradient.
// ----------------------------------------------------------------------------
package tscg_pkg;

   localparam int MAX_ROWS_DEF = 4096;

   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int COLOR_W     = CHAN_W * NUM_CHAN;
   localparam int ROW_CNT_W   = 13;
   localparam int FRAC_W      = 16;
   localparam int ROW_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = CHAN_W / DIV_STEPS_PER_STAGE;

   localparam logic [COLOR_W-1:0]   TOP_COLOR_RST    = '0;
   localparam logic [COLOR_W-1:0]   BOTTOM_COLOR_RST = '0;
   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST    = ROW_CNT_W'(1);
   localparam logic [FRAC_W-1:0]    MIDPOINT_RST     = FRAC_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_COLOR    = 2'd0,
      CSR_BOTTOM_COLOR = 2'd1,
      CSR_ROW_COUNT    = 2'd2,
      CSR_MIDPOINT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0]   top_color;
      logic [COLOR_W-1:0]   bottom_color;
      logic [ROW_CNT_W-1:0] row_count;
      logic [FRAC_W-1:0]    midpoint_fraction;
   } cfg_type;

   // channel 0 is red (top byte), 2 is blue
   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                  input int idx);
      return color[CHAN_W*(NUM_CHAN-1-idx) +: CHAN_W];
   endfunction

endpackage

[hw/rtl/two_segment_color_gradient.sv]
// ----------------------------------------------------------------------------
// two_segment_color_gradient
// Returns the RGB color of a requested row of a two-segment vertical gradient.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one color per clock while no stall
// holds the pipeline; each request passes through 3 front stages for clamping,
// midpoint and the delta product, 4 stages of a restoring divider that resolves
// 2 quotient bits per stage, and 1 output register.
// Stalls on rsp_ stall only the full stages behind the output, so requests
// keep entering while empty stages remain. Write the csr_ registers only
// while no request is in flight.
// ----------------------------------------------------------------------------
module two_segment_color_gradient #(
   parameter int MAX_ROWS = tscg_pkg::MAX_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tscg_pkg::ROW_W-1:0]         req_row_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tscg_pkg::CHAN_W-1:0]        rsp_red,
   output logic [tscg_pkg::CHAN_W-1:0]        rsp_green,
   output logic [tscg_pkg::CHAN_W-1:0]        rsp_blue,
   input  logic                               csr_write_enable,
   input  logic [tscg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tscg_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int HW = $clog2(MAX_ROWS + 1);
   localparam int DW = HW + 1;
   localparam int PW = DW + tscg_pkg::CHAN_W;

   tscg_pkg::cfg_type cfg_ff;

   logic                                                  f_valid, f_stall;
   logic [tscg_pkg::NUM_CHAN-1:0][PW-1:0]                 f_prod;
   logic [DW-1:0]                                         f_den;
   logic                                                  d_valid, d_stall;
   logic [tscg_pkg::NUM_CHAN-1:0][tscg_pkg::CHAN_W-1:0]   d_quo;
   logic [tscg_pkg::NUM_CHAN-1:0][DW-1:0]                 d_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_color         <= tscg_pkg::TOP_COLOR_RST;
         cfg_ff.bottom_color      <= tscg_pkg::BOTTOM_COLOR_RST;
         cfg_ff.row_count         <= tscg_pkg::ROW_COUNT_RST;
         cfg_ff.midpoint_fraction <= tscg_pkg::MIDPOINT_RST;
      end else if (csr_write_enable) begin
         unique case (tscg_pkg::csr_index_type'(csr_index))
            tscg_pkg::CSR_TOP_COLOR: begin
               cfg_ff.top_color <= csr_write_data[tscg_pkg::COLOR_W-1:0];
            end
            tscg_pkg::CSR_BOTTOM_COLOR: begin
               cfg_ff.bottom_color <= csr_write_data[tscg_pkg::COLOR_W-1:0];
            end
            tscg_pkg::CSR_ROW_COUNT: begin
               cfg_ff.row_count <= csr_write_data[tscg_pkg::ROW_CNT_W-1:0];
            end
            tscg_pkg::CSR_MIDPOINT: begin
               cfg_ff.midpoint_fraction <= csr_write_data[tscg_pkg::FRAC_W-1:0];
            end
         endcase
      end
   end

   tscg_front #(.MAX_ROWS(MAX_ROWS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_valid),
      .in_row_index (req_row_index),
      .in_stall     (req_stall),
      .out_valid    (f_valid),
      .out_prod     (f_prod),
      .out_den      (f_den),
      .out_stall    (f_stall)
   );

   tscg_div #(.MAX_ROWS(MAX_ROWS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_prod   (f_prod),
      .in_den    (f_den),
      .in_stall  (f_stall),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_rem   (d_rem),
      .out_stall (d_stall)
   );

   tscg_out #(.MAX_ROWS(MAX_ROWS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (d_valid),
      .in_quo    (d_quo),
      .in_rem    (d_rem),
      .in_stall  (d_stall),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue),
      .rsp_stall (rsp_stall)
   );

endmodule

[hw/rtl/tscg_front.sv]
// ----------------------------------------------------------------------------
// tscg_front
// Row/height clamping, midpoint, segment select and |delta| * position product.
// Three register stages.
// ----------------------------------------------------------------------------
module tscg_front #(
   parameter int  MAX_ROWS = tscg_pkg::MAX_ROWS_DEF,
   localparam int HW       = $clog2(MAX_ROWS + 1),
   localparam int DW       = HW + 1,
   localparam int PW       = DW + tscg_pkg::CHAN_W
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  tscg_pkg::cfg_type                           cfg,
   input  logic                                        in_valid,
   input  logic [tscg_pkg::ROW_W-1:0]                  in_row_index,
   output logic                                        in_stall,
   output logic                                        out_valid,
   output logic [tscg_pkg::NUM_CHAN-1:0][PW-1:0]       out_prod,
   output logic [DW-1:0]                               out_den,
   input  logic                                        out_stall
);

   localparam int MPW = tscg_pkg::FRAC_W + HW;

   logic           hold1, hold2, hold3;

   // stage 1
   logic [HW-1:0]  h_in;
   logic [HW-1:0]  y_in;
   logic [MPW-1:0] mprod;
   logic           v1_ff;
   logic [HW-1:0]  y1_ff, h1_ff, mh1_ff;

   // stage 2
   logic [HW-1:0]  hm1, m, km;
   logic           upper;
   logic [DW-1:0]  den_in, t_in;
   logic           v2_ff;
   logic [DW-1:0]  den2_ff, t2_ff;

   // stage 3
   logic [tscg_pkg::NUM_CHAN-1:0][PW-1:0] prod_in;
   logic                                  v3_ff;
   logic [tscg_pkg::NUM_CHAN-1:0][PW-1:0] prod3_ff;
   logic [DW-1:0]                         den3_ff;

   assign hold3    = v3_ff && out_stall;
   assign hold2    = v2_ff && hold3;
   assign hold1    = v1_ff && hold2;
   assign in_stall = hold1;

   always_comb begin
      priority if (cfg.row_count == '0) begin
         h_in = HW'(1);
      end else if (cfg.row_count > MAX_ROWS) begin
         h_in = HW'(MAX_ROWS);
      end else begin
         h_in = HW'(cfg.row_count);
      end
      if (in_row_index >= h_in) begin
         y_in = h_in - HW'(1);
      end else begin
         y_in = HW'(in_row_index);
      end
   end

   assign mprod = MPW'(cfg.midpoint_fraction) * MPW'(h_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (!hold1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) begin
         y1_ff  <= y_in;
         h1_ff  <= h_in;
         mh1_ff <= mprod[MPW-1:tscg_pkg::FRAC_W];
      end
   end

   always_comb begin
      hm1   = h1_ff - HW'(1);
      m     = (mh1_ff > hm1) ? hm1 : mh1_ff;
      upper = y1_ff < m;
      km    = h1_ff - m;
      if (upper) begin
         den_in = {m, 1'b0};
         t_in   = {1'b0, y1_ff};
      end else begin
         den_in = {km, 1'b0};
         t_in   = {1'b0, km} + {1'b0, y1_ff} - {1'b0, m};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (!hold2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold2) begin
         den2_ff <= den_in;
         t2_ff   <= t_in;
      end
   end

   always_comb begin
      logic [tscg_pkg::CHAN_W-1:0] s, e, ad;
      for (int c = 0; c < tscg_pkg::NUM_CHAN; c++) begin
         s  = tscg_pkg::chan_of(cfg.top_color, c);
         e  = tscg_pkg::chan_of(cfg.bottom_color, c);
         ad = (e >= s) ? (e - s) : (s - e);
         prod_in[c] = PW'(ad) * PW'(t2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (!hold3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold3) begin
         prod3_ff <= prod_in;
         den3_ff  <= den2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_prod  = prod3_ff;
   assign out_den   = den3_ff;

`ifndef SYNTHESIS
   a_pos_below_den: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (den2_ff != '0) && (t2_ff < den2_ff))
      else $error("segment position not below denominator");
`endif

endmodule

[hw/rtl/tscg_div.sv]
// ----------------------------------------------------------------------------
// tscg_div
// Pipelined restoring divider, one lane per channel, shared denominator.
// Two quotient bits per stage.
// ----------------------------------------------------------------------------
module tscg_div #(
   parameter int  MAX_ROWS = tscg_pkg::MAX_ROWS_DEF,
   localparam int HW       = $clog2(MAX_ROWS + 1),
   localparam int DW       = HW + 1,
   localparam int PW       = DW + tscg_pkg::CHAN_W
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic [tscg_pkg::NUM_CHAN-1:0][PW-1:0]           in_prod,
   input  logic [DW-1:0]                                   in_den,
   output logic                                            in_stall,
   output logic                                            out_valid,
   output logic [tscg_pkg::NUM_CHAN-1:0][tscg_pkg::CHAN_W-1:0] out_quo,
   output logic [tscg_pkg::NUM_CHAN-1:0][DW-1:0]           out_rem,
   input  logic                                            out_stall
);

   localparam int NST = tscg_pkg::DIV_STAGES;
   localparam int NCH = tscg_pkg::NUM_CHAN;
   localparam int CW  = tscg_pkg::CHAN_W;

   logic [NST-1:0]                 hold;
   logic [NST-1:0]                 src_v;
   logic [DW-1:0]                  src_den [NST];
   logic [NCH-1:0][DW-1:0]         src_r   [NST];
   logic [NCH-1:0][CW-1:0]         src_lo  [NST];
   logic [NCH-1:0][CW-1:0]         src_q   [NST];

   logic                           v_ff    [NST];
   logic [DW-1:0]                  den_ff  [NST];
   logic [NCH-1:0][DW-1:0]         r_ff    [NST];
   logic [NCH-1:0][CW-1:0]         lo_ff   [NST];
   logic [NCH-1:0][CW-1:0]         q_ff    [NST];

   logic [NCH-1:0][DW-1:0]         r_in    [NST];
   logic [NCH-1:0][CW-1:0]         lo_in   [NST];
   logic [NCH-1:0][CW-1:0]         q_in    [NST];

   assign in_stall = hold[0];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_v[k]   = in_valid;
         assign src_den[k] = in_den;
         for (genvar c = 0; c < NCH; c++) begin : g_ch
            assign src_r[k][c]  = in_prod[c][PW-1:CW];
            assign src_lo[k][c] = in_prod[c][CW-1:0];
            assign src_q[k][c]  = '0;
         end
      end else begin : g_next
         assign src_v[k]   = v_ff[k-1];
         assign src_den[k] = den_ff[k-1];
         assign src_r[k]   = r_ff[k-1];
         assign src_lo[k]  = lo_ff[k-1];
         assign src_q[k]   = q_ff[k-1];
      end

      if (k == NST - 1) begin : g_last
         assign hold[k] = v_ff[k] && out_stall;
      end else begin : g_mid
         assign hold[k] = v_ff[k] && hold[k+1];
      end

      always_comb begin
         logic [DW:0]   x;
         logic [DW-1:0] r;
         logic [CW-1:0] lo, q;
         for (int c = 0; c < NCH; c++) begin
            r  = src_r[k][c];
            lo = src_lo[k][c];
            q  = src_q[k][c];
            for (int s = 0; s < tscg_pkg::DIV_STEPS_PER_STAGE; s++) begin
               x  = {r, lo[CW-1]};
               lo = lo << 1;
               if (x >= {1'b0, src_den[k]}) begin
                  r = DW'(x - {1'b0, src_den[k]});
                  q = {q[CW-2:0], 1'b1};
               end else begin
                  r = x[DW-1:0];
                  q = {q[CW-2:0], 1'b0};
               end
            end
            r_in[k][c]  = r;
            lo_in[k][c] = lo;
            q_in[k][c]  = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (!hold[k]) begin
            v_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[k]) begin
            den_ff[k] <= src_den[k];
            r_ff[k]   <= r_in[k];
            lo_ff[k]  <= lo_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_quo   = q_ff[NST-1];
   assign out_rem   = r_ff[NST-1];

`ifndef SYNTHESIS
   for (genvar c = 0; c < NCH; c++) begin : g_chk
      a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
         v_ff[NST-1] |-> (r_ff[NST-1][c] < den_ff[NST-1]))
         else $error("divider remainder not below denominator");
   end
`endif

endmodule

[hw/rtl/tscg_out.sv]
// ----------------------------------------------------------------------------
// tscg_out
// Applies delta sign with floor rounding, adds start channel, output register.
// ----------------------------------------------------------------------------
module tscg_out #(
   parameter int  MAX_ROWS = tscg_pkg::MAX_ROWS_DEF,
   localparam int HW       = $clog2(MAX_ROWS + 1),
   localparam int DW       = HW + 1
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  tscg_pkg::cfg_type                                   cfg,
   input  logic                                                in_valid,
   input  logic [tscg_pkg::NUM_CHAN-1:0][tscg_pkg::CHAN_W-1:0] in_quo,
   input  logic [tscg_pkg::NUM_CHAN-1:0][DW-1:0]               in_rem,
   output logic                                                in_stall,
   output logic                                                rsp_valid,
   output logic [tscg_pkg::CHAN_W-1:0]                         rsp_red,
   output logic [tscg_pkg::CHAN_W-1:0]                         rsp_green,
   output logic [tscg_pkg::CHAN_W-1:0]                         rsp_blue,
   input  logic                                                rsp_stall
);

   localparam int NCH = tscg_pkg::NUM_CHAN;
   localparam int CW  = tscg_pkg::CHAN_W;

   logic                    hold;
   logic [NCH-1:0][CW-1:0]  val_in;
   logic                    valid_ff;
   logic [NCH-1:0][CW-1:0]  val_ff;

   assign hold     = valid_ff && rsp_stall;
   assign in_stall = hold;

   // negative delta: floor of -(a/b) is -(q + (r != 0))
   always_comb begin
      logic [CW-1:0] s, e;
      logic [CW:0]   sum;
      for (int c = 0; c < NCH; c++) begin
         s = tscg_pkg::chan_of(cfg.top_color, c);
         e = tscg_pkg::chan_of(cfg.bottom_color, c);
         if (e < s) begin
            sum = {1'b0, s} - {1'b0, in_quo[c]} - (CW+1)'(in_rem[c] != '0);
         end else begin
            sum = {1'b0, s} + {1'b0, in_quo[c]};
         end
         val_in[c] = sum[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         val_ff <= val_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_red   = val_ff[0];
   assign rsp_green = val_ff[1];
   assign rsp_blue  = val_ff[2];

`ifndef SYNTHESIS
   for (genvar c = 0; c < NCH; c++) begin : g_chk
      a_between_ends: assert property (@(posedge clock) disable iff (reset)
         valid_ff |->
            ((val_ff[c] >= tscg_pkg::chan_of(cfg.top_color, c)) &&
             (val_ff[c] <= tscg_pkg::chan_of(cfg.bottom_color, c))) ||
            ((val_ff[c] <= tscg_pkg::chan_of(cfg.top_color, c)) &&
             (val_ff[c] >= tscg_pkg::chan_of(cfg.bottom_color, c))))
         else $error("channel outside start/end range");
   end
`endif

endmodule

[sim/two_segment_color_gradient_tb.sv]
// ----------------------------------------------------------------------------
// two_segment_color_gradient_tb
// Self-checking bench for the two-segment color gradient.
// ----------------------------------------------------------------------------
// Programs a series of gradients through the csr_ port and sends row requests
// under random request gaps and response stalls. A scoreboard class predicts
// each row color from its own copy of the registers and compares every
// returned color, channel by channel, in order.
// The run starts with hand-picked cases: reset values, extreme colors, zero
// and oversized heights, midpoint at the top, and rows past the end.
// Random gradients follow; the final phases run with no idling.
// ----------------------------------------------------------------------------
module two_segment_color_gradient_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 30;
   localparam int ROWS_PER_PHASE = 30;
   localparam int CALM_PHASES = 4;
   localparam int CW = tscg_pkg::CHAN_W;
   localparam int COLW = tscg_pkg::COLOR_W;
   localparam int RCW = tscg_pkg::ROW_CNT_W;
   localparam int FW = tscg_pkg::FRAC_W;
   localparam int RW = tscg_pkg::ROW_W;
   localparam int DATW = tscg_pkg::CSR_DATA_W;
   localparam int MAXR = tscg_pkg::MAX_ROWS_DEF;

   typedef struct packed {
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
   } row_color_type;

   class gradient_scoreboard_type;
      logic [COLW-1:0]  top_color;
      logic [COLW-1:0]  bottom_color;
      logic [RCW-1:0]   row_count;
      logic [FW-1:0]    mid_frac;
      row_color_type    expected_colors[$];
      int               errors;

      function new();
         top_color    = tscg_pkg::TOP_COLOR_RST;
         bottom_color = tscg_pkg::BOTTOM_COLOR_RST;
         row_count    = tscg_pkg::ROW_COUNT_RST;
         mid_frac     = tscg_pkg::MIDPOINT_RST;
         errors       = 0;
      endfunction

      function void write_reg(tscg_pkg::csr_index_type idx, logic [DATW-1:0] data);
         case (idx)
            tscg_pkg::CSR_TOP_COLOR:    top_color    = data[COLW-1:0];
            tscg_pkg::CSR_BOTTOM_COLOR: bottom_color = data[COLW-1:0];
            tscg_pkg::CSR_ROW_COUNT:    row_count    = data[RCW-1:0];
            tscg_pkg::CSR_MIDPOINT:     mid_frac     = data[FW-1:0];
            default: ;
         endcase
      endfunction

      function logic [CW-1:0] blend(logic [CW-1:0] s8, logic [CW-1:0] e8,
                                    longint y, longint m, longint h);
         longint s;
         longint d;
         longint num;
         longint den;
         longint q;
         s = longint'(s8);
         d = longint'(e8) - s;
         if (y < m) begin
            num = s * 2 * m + d * y;
            den = 2 * m;
         end else begin
            num = s * 2 * (h - m) + d * ((h - m) + (y - m));
            den = 2 * (h - m);
         end
         if (den <= 0)
            return '0;
         q = num / den;
         if (q < 0)
            q = 0;
         if (q > 255)
            q = 255;
         return q[CW-1:0];
      endfunction

      function void note_request(logic [RW-1:0] row);
         longint        h;
         longint        y;
         longint        m;
         row_color_type c;
         h = longint'(row_count);
         if (h == 0)
            h = 1;
         if (h > MAXR)
            h = MAXR;
         y = longint'(row);
         if (y >= h)
            y = h - 1;
         m = (longint'(mid_frac) * h) >> 16;
         if (m > h - 1)
            m = h - 1;
         c.red   = blend(top_color[23:16], bottom_color[23:16], y, m, h);
         c.green = blend(top_color[15:8],  bottom_color[15:8],  y, m, h);
         c.blue  = blend(top_color[7:0],   bottom_color[7:0],   y, m, h);
         expected_colors.push_back(c);
      endfunction

      function void check_color(logic [CW-1:0] r, logic [CW-1:0] g,
                                logic [CW-1:0] b);
         row_color_type want;
         if (expected_colors.size() == 0) begin
            $display("%0t: unexpected response r=%0d g=%0d b=%0d", $time, r, g, b);
            errors++;
            return;
         end
         want = expected_colors.pop_front();
         if (r !== want.red) begin
            $display("%0t: red expected %0d got %0d", $time, want.red, r);
            errors++;
         end
         if (g !== want.green) begin
            $display("%0t: green expected %0d got %0d", $time, want.green, g);
            errors++;
         end
         if (b !== want.blue) begin
            $display("%0t: blue expected %0d got %0d", $time, want.blue, b);
            errors++;
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [RW-1:0]                     req_row_index = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [CW-1:0]                     rsp_red;
   logic [CW-1:0]                     rsp_green;
   logic [CW-1:0]                     rsp_blue;
   logic                              csr_write_enable = 1'b0;
   logic [tscg_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [DATW-1:0]                   csr_write_data = '0;

   gradient_scoreboard_type grid = new();
   int cycle_count = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int gap_pct = 0;
   bit calm = 1'b0;

   two_segment_color_gradient u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_index    (req_row_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(0, 2));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         grid.check_color(rsp_red, rsp_green, rsp_blue);
   end

   // called and returns at a falling edge
   task automatic send_row(input logic [RW-1:0] row);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_row_index <= row;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      grid.note_request(row);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (grid.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_gradient(input logic [COLW-1:0] sc, input logic [COLW-1:0] ec,
                                   input logic [RCW-1:0] rc,
                                   input logic [FW-1:0] mf);
      tscg_pkg::csr_index_type idx;
      logic [DATW-1:0]         data;
      for (int i = 0; i < 4; i++) begin
         idx = tscg_pkg::csr_index_type'(i);
         case (idx)
            tscg_pkg::CSR_TOP_COLOR:    data = sc;
            tscg_pkg::CSR_BOTTOM_COLOR: data = ec;
            tscg_pkg::CSR_ROW_COUNT:    data = DATW'(rc);
            default:                    data = DATW'(mf);
         endcase
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= data;
         grid.write_reg(idx, data);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase();
      logic [COLW-1:0] sc;
      logic [COLW-1:0] ec;
      logic [RCW-1:0]  rc;
      logic [FW-1:0]   mf;
      int              h;
      sc = COLW'($urandom);
      ec = COLW'($urandom);
      if ($urandom_range(0, 7) == 0)
         sc = ($urandom_range(0, 1) != 0) ? '1 : '0;
      if ($urandom_range(0, 7) == 0)
         ec = ($urandom_range(0, 1) != 0) ? '1 : '0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: rc = RCW'($urandom_range(1, 40));
         5, 6:          rc = RCW'($urandom_range(1, MAXR));
         7:             rc = RCW'($urandom_range(0, 8191));
         8:             rc = RCW'(MAXR);
         default:       rc = RCW'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 7))
         0:       mf = '0;
         1:       mf = '1;
         default: mf = FW'($urandom);
      endcase
      h = (rc == 0) ? 1 : (rc > MAXR) ? MAXR : int'(rc);
      program_gradient(sc, ec, rc, mf);
      for (int i = 0; i < ROWS_PER_PHASE; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_row(RW'($urandom));
         else
            send_row(RW'($urandom_range(0, h - 1)));
      end
      settle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      stall_pct = 20;
      gap_pct   = 25;

      // reset register values
      send_row('0);
      send_row('1);
      settle();

      // full-range ramp, midpoint at the last row
      program_gradient(24'h000000, 24'hFFFFFF, 13'd4096, 16'hFFFF);
      send_row(12'd0);
      send_row(12'd1);
      send_row(12'd2047);
      send_row(12'd4094);
      send_row(12'd4095);
      settle();

      // zero height
      program_gradient(24'hFFFFFF, 24'h000000, 13'd0, 16'h0000);
      send_row(12'd0);
      send_row(12'd4095);
      settle();

      // oversized height, midpoint at top
      program_gradient(24'hFF00AA, 24'h00FF55, 13'd8191, 16'h0000);
      send_row(12'd0);
      send_row(12'd1000);
      send_row(12'd4095);
      settle();

      // two rows, row past the end
      program_gradient(24'h123456, 24'hFEDCBA, 13'd2, 16'h8000);
      send_row(12'd0);
      send_row(12'd1);
      send_row(12'd2);
      settle();

      // around the midpoint
      program_gradient(24'h80FF01, 24'h0100FE, 13'd100, 16'h4000);
      send_row(12'd24);
      send_row(12'd25);
      send_row(12'd26);
      send_row(12'd99);
      send_row(12'd4095);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 50;
         endcase
         if (p >= RANDOM_PHASES - CALM_PHASES)
            calm = 1'b1;
         random_phase();
      end

      if (grid.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
